>>> hdl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared types, constants and buffer type helpers for the deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // Buffer types carried with each result.
  localparam logic [2:0] BT_TEXT_FRAG = 3'd0;
  localparam logic [2:0] BT_BIN_FRAG  = 3'd1;
  localparam logic [2:0] BT_TEXT_MSG  = 3'd2;
  localparam logic [2:0] BT_BIN_MSG   = 3'd3;
  localparam logic [2:0] BT_CLOSE     = 3'd4;
  localparam logic [2:0] BT_PING      = 3'd5;
  localparam logic [2:0] BT_PONG      = 3'd6;

  // Frame opcodes.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Configuration.
  localparam int          PADDR_W       = 4;
  localparam logic [63:0] MAX_LEN_RESET = 64'h0000_0000_0040_0000;
  localparam logic        REG_MAX_LEN   = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [2:0] buffer_type;
    logic       frame_end;
    logic       length_error;
  } result_t;

  function automatic logic [2:0] control_type(input logic [3:0] op,
                                              input logic [2:0] keep);
    logic [2:0] t;
    case (op)
      OP_CLOSE: t = BT_CLOSE;
      OP_PING:  t = BT_PING;
      OP_PONG:  t = BT_PONG;
      default:  t = keep;
    endcase
    return t;
  endfunction

  // Type of a payload byte that does not end its frame.
  function automatic logic [2:0] mid_type(input logic [3:0] op,
                                          input logic [2:0] prev);
    logic [2:0] t;
    case (op)
      OP_TEXT: t = BT_TEXT_FRAG;
      OP_BIN:  t = BT_BIN_FRAG;
      default: t = control_type(op, prev);
    endcase
    return t;
  endfunction

  // Type of the last result of a frame.
  function automatic logic [2:0] end_type(input logic [3:0] op,
                                          input logic       fin,
                                          input logic [2:0] prev);
    logic [2:0] t;
    if (fin) begin
      case (op)
        OP_CONT: begin
          if (prev == BT_TEXT_FRAG) begin
            t = BT_TEXT_MSG;
          end else if (prev == BT_BIN_FRAG) begin
            t = BT_BIN_MSG;
          end else begin
            t = prev;
          end
        end
        OP_TEXT: t = BT_TEXT_MSG;
        OP_BIN:  t = BT_BIN_MSG;
        default: t = control_type(op, prev);
      endcase
    end else begin
      t = mid_type(op, prev);
    end
    return t;
  endfunction

endpackage

>>> hdl/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received WebSocket frames byte by byte and delivers unmasked
// payload bytes tagged with their buffer type.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ---------------------------------------
//  input     in_valid / in_ready    rx_byte
//  output    out_valid / out_ready  data_byte, has_data, buffer_type,
//                                   frame_end, length_error
//  config    APB psel/penable       paddr, pwdata, prdata (64 bit)
//
// Each input beat is decoded in the cycle it is accepted, one byte per clock,
// and its result, if any, is pushed into the two-entry queue on that edge.
// in_ready drops only while that queue is full, so a stalled output beat does
// not stop input while a slot is free. Synchronous reset clears the parser,
// the queue and max_payload_length (back to 4 MiB). After the error beat of an
// oversize frame, input beats are still accepted but ignored until reset.
module websocket_frame_deframer_unit (
  input  logic                         clk,
  input  logic                         rst,
  // Byte input.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   rx_byte,
  // Result output.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   data_byte,
  output logic                         has_data,
  output logic [2:0]                   buffer_type,
  output logic                         frame_end,
  output logic                         length_error,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsfd_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  logic [63:0]       max_payload_length;
  logic              in_accept;
  logic              res_valid;
  logic              queue_full;
  wsfd_pkg::result_t res;
  wsfd_pkg::result_t out_res;

  // Registers sit on 8-byte boundaries; bit 3 selects the register.
  assign pready = 1'b1;
  assign prdata = (paddr[3] == wsfd_pkg::REG_MAX_LEN) ? max_payload_length : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= wsfd_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && (paddr[3] == wsfd_pkg::REG_MAX_LEN)) begin
      max_payload_length <= pwdata;
    end
  end

  assign in_ready  = !queue_full;
  assign in_accept = in_valid && in_ready;

  // The parser state advances on each accepted beat until an oversize frame
  // halts it; its result, if any, is pushed into the queue on the same edge.
  wsfd_parser u_parser (
    .clk                (clk),
    .rst                (rst),
    .step_in            (in_accept),
    .rx_byte            (rx_byte),
    .max_payload_length (max_payload_length),
    .res_valid          (res_valid),
    .res                (res)
  );

  wsfd_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign data_byte    = out_res.data_byte;
  assign has_data     = out_res.has_data;
  assign buffer_type  = out_res.buffer_type;
  assign frame_end    = out_res.frame_end;
  assign length_error = out_res.length_error;

endmodule

>>> hdl/wsfd_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame header parser and unmasker
// Holds the frame state and turns each accepted byte into at most one result.
// ----------------------------------------------------------------------------
module wsfd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_in,
  input  logic [7:0]       rx_byte,
  input  logic [63:0]      max_payload_length,
  output logic             res_valid,
  output wsfd_pkg::result_t res
);

  wsfd_pkg::phase_t phase, phase_next;
  logic [3:0]  header_byte_count, header_byte_count_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        frame_fin, frame_fin_next;
  logic        frame_masked, frame_masked_next;
  logic [63:0] payload_remaining, payload_remaining_next;
  logic [31:0] masking_key, masking_key_next;
  logic [1:0]  key_index, key_index_next;
  logic [2:0]  previous_type, previous_type_next;
  logic        halted, halted_next;

  logic        step;
  logic [6:0]  len7;
  logic        len_is_ext;
  logic [63:0] ext_len;
  logic [3:0]  cnt_dec;
  logic [63:0] fin_len;
  logic        finish_now;
  logic        len_over;
  logic        len_zero;
  logic [63:0] rem_dec;
  logic        last_payload;
  logic [7:0]  key_byte;
  logic [2:0]  end_t;

  // Shared decode of the current byte against the frame state.
  always_comb begin
    step         = step_in && !halted;
    len7         = rx_byte[6:0];
    len_is_ext   = (len7 == wsfd_pkg::LEN_EXT16) || (len7 == wsfd_pkg::LEN_EXT64);
    ext_len      = {payload_remaining[55:0], rx_byte};
    cnt_dec      = header_byte_count - 4'd1;
    rem_dec      = payload_remaining - 64'd1;
    last_payload = (rem_dec == 64'd0);
    end_t        = wsfd_pkg::end_type(frame_opcode, frame_fin, previous_type);
    fin_len      = '0;
    finish_now   = 1'b0;
    case (phase)
      wsfd_pkg::PH_HDR1: begin
        fin_len    = {57'd0, len7};
        finish_now = !len_is_ext && !rx_byte[7];
      end
      wsfd_pkg::PH_EXTLEN: begin
        fin_len    = ext_len;
        finish_now = (cnt_dec == 4'd0) && !frame_masked;
      end
      wsfd_pkg::PH_KEY: begin
        fin_len    = payload_remaining;
        finish_now = (cnt_dec == 4'd0);
      end
      default: begin
        fin_len    = '0;
        finish_now = 1'b0;
      end
    endcase
    len_over = (fin_len > max_payload_length);
    len_zero = (fin_len == 64'd0);
    case (key_index)
      2'd0:    key_byte = masking_key[31:24];
      2'd1:    key_byte = masking_key[23:16];
      2'd2:    key_byte = masking_key[15:8];
      default: key_byte = masking_key[7:0];
    endcase
  end

  // Result of the current byte.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (step) begin
      if (finish_now) begin
        if (len_over) begin
          res_valid        = 1'b1;
          res.length_error = 1'b1;
        end else if (len_zero) begin
          res_valid       = 1'b1;
          res.buffer_type = end_t;
          res.frame_end   = 1'b1;
        end
      end else if (phase == wsfd_pkg::PH_PAYLOAD) begin
        res_valid       = 1'b1;
        res.data_byte   = frame_masked ? (rx_byte ^ key_byte) : rx_byte;
        res.has_data    = 1'b1;
        res.buffer_type = last_payload ? end_t
                                       : wsfd_pkg::mid_type(frame_opcode, previous_type);
        res.frame_end   = last_payload;
      end
    end
  end

  // Next state.
  always_comb begin
    phase_next             = phase;
    header_byte_count_next = header_byte_count;
    frame_opcode_next      = frame_opcode;
    frame_fin_next         = frame_fin;
    frame_masked_next      = frame_masked;
    payload_remaining_next = payload_remaining;
    masking_key_next       = masking_key;
    key_index_next         = key_index;
    previous_type_next     = previous_type;
    halted_next            = halted;
    if (step) begin
      case (phase)
        wsfd_pkg::PH_HDR0: begin
          frame_opcode_next = rx_byte[3:0];
          frame_fin_next    = rx_byte[7];
          phase_next        = wsfd_pkg::PH_HDR1;
        end
        wsfd_pkg::PH_HDR1: begin
          frame_masked_next = rx_byte[7];
          if (len_is_ext) begin
            payload_remaining_next = '0;
            header_byte_count_next = (len7 == wsfd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
            phase_next             = wsfd_pkg::PH_EXTLEN;
          end else begin
            payload_remaining_next = {57'd0, len7};
            if (rx_byte[7]) begin
              phase_next             = wsfd_pkg::PH_KEY;
              header_byte_count_next = 4'd4;
              masking_key_next       = '0;
            end
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          payload_remaining_next = ext_len;
          header_byte_count_next = cnt_dec;
          if ((cnt_dec == 4'd0) && frame_masked) begin
            phase_next             = wsfd_pkg::PH_KEY;
            header_byte_count_next = 4'd4;
            masking_key_next       = '0;
          end
        end
        wsfd_pkg::PH_KEY: begin
          masking_key_next       = {masking_key[23:0], rx_byte};
          header_byte_count_next = cnt_dec;
        end
        wsfd_pkg::PH_PAYLOAD: begin
          key_index_next         = key_index + 2'd1;
          payload_remaining_next = rem_dec;
          previous_type_next     = res.buffer_type;
          if (last_payload) begin
            phase_next = wsfd_pkg::PH_HDR0;
          end
        end
        default: begin
          phase_next = wsfd_pkg::PH_HDR0;
        end
      endcase
      if (finish_now) begin
        key_index_next         = '0;
        header_byte_count_next = '0;
        if (len_over) begin
          halted_next = 1'b1;
        end else if (len_zero) begin
          previous_type_next = end_t;
          phase_next         = wsfd_pkg::PH_HDR0;
        end else begin
          phase_next = wsfd_pkg::PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wsfd_pkg::PH_HDR0;
      header_byte_count <= '0;
      frame_opcode      <= '0;
      frame_fin         <= 1'b0;
      frame_masked      <= 1'b0;
      payload_remaining <= '0;
      masking_key       <= '0;
      key_index         <= '0;
      previous_type     <= '0;
      halted            <= 1'b0;
    end else begin
      phase             <= phase_next;
      header_byte_count <= header_byte_count_next;
      frame_opcode      <= frame_opcode_next;
      frame_fin         <= frame_fin_next;
      frame_masked      <= frame_masked_next;
      payload_remaining <= payload_remaining_next;
      masking_key       <= masking_key_next;
      key_index         <= key_index_next;
      previous_type     <= previous_type_next;
      halted            <= halted_next;
    end
  end

endmodule

>>> hdl/wsfd_out_queue.sv
// ----------------------------------------------------------------------------
// WebSocket deframer result queue
// Two-entry queue that decouples result production from the output stall.
// ----------------------------------------------------------------------------
module wsfd_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsfd_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output wsfd_pkg::result_t out_data
);

  wsfd_pkg::result_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds framed byte streams into the deframer while a local predictor
// parses the same stream. Every result beat is checked field by field
// against the oldest predicted beat. Covers all opcodes, fragmentation,
// the three length encodings, masking, zero-length frames, the payload
// length limit register and the halt that follows an oversize frame.
// ----------------------------------------------------------------------------
module tb_top;

  // Encodings of the payload length in the second header byte.
  localparam int FORM_LEN7  = 0;
  localparam int FORM_LEN16 = 1;
  localparam int FORM_LEN64 = 2;

  // Two reserved opcodes used by the directed frames.
  localparam logic [3:0] OP_RSV_LOW  = 4'h3;
  localparam logic [3:0] OP_RSV_HIGH = 4'hF;

  // The only register is 64 bits wide, so registers sit on 8-byte strides.
  localparam logic [wsfd_pkg::PADDR_W-1:0] MAX_LEN_ADDR =
    wsfd_pkg::PADDR_W'(8 * wsfd_pkg::REG_MAX_LEN);

  // Cycles without any accepted beat or bus access before the run is called hung.
  localparam int WATCHDOG_CYCLES = 2000;
  // Settling time given to the block once the last predicted beat has arrived.
  localparam int DRAIN_CYCLES    = 8;

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic [7:0]                    rx_byte      = 8'h00;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic [7:0]                    data_byte;
  logic                          has_data;
  logic [2:0]                    buffer_type;
  logic                          frame_end;
  logic                          length_error;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [wsfd_pkg::PADDR_W-1:0]  paddr        = '0;
  logic [63:0]                   pwdata       = '0;
  logic [63:0]                   prdata;
  logic                          pready;

  websocket_frame_deframer_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (data_byte),
    .has_data     (has_data),
    .buffer_type  (buffer_type),
    .frame_end    (frame_end),
    .length_error (length_error),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the parser of the block: where we are in the
  // header, what the current frame announced, and the type of the last beat,
  // which continuation and reserved-opcode frames inherit.
  // --------------------------------------------------------------------------
  wsfd_pkg::phase_t parse_state = wsfd_pkg::PH_HDR0;
  logic [3:0]  hdr_left    = '0;
  logic [3:0]  fr_op       = '0;
  logic        fr_fin      = 1'b0;
  logic        fr_masked   = 1'b0;
  logic [63:0] bytes_left  = '0;
  logic [31:0] mask_key    = '0;
  logic [1:0]  key_pos     = '0;
  logic [2:0]  last_type   = wsfd_pkg::BT_TEXT_FRAG;
  logic        halted      = 1'b0;
  logic [63:0] cfg_max_len = wsfd_pkg::MAX_LEN_RESET;

  // Result beats predicted but not yet seen on the output.
  wsfd_pkg::result_t expected_beats[$];

  int          mismatches   = 0;
  int          bytes_sent   = 0;
  int          quiet_cycles = 0;
  int          stall_left   = 0;
  bit          idle_on      = 1'b1;

  // Buffer type of a payload beat or of a frame-closing beat. Text and binary
  // become messages only on the last beat of a FIN frame; continuation frames
  // promote an inherited fragment type the same way. Control opcodes always
  // map to their own type, and reserved opcodes inherit whatever came last.
  function automatic logic [2:0] beat_type(input logic at_end);
    logic [2:0] t;
    case (fr_op)
      wsfd_pkg::OP_TEXT:  t = (at_end && fr_fin) ? wsfd_pkg::BT_TEXT_MSG
                                                 : wsfd_pkg::BT_TEXT_FRAG;
      wsfd_pkg::OP_BIN:   t = (at_end && fr_fin) ? wsfd_pkg::BT_BIN_MSG
                                                 : wsfd_pkg::BT_BIN_FRAG;
      wsfd_pkg::OP_CLOSE: t = wsfd_pkg::BT_CLOSE;
      wsfd_pkg::OP_PING:  t = wsfd_pkg::BT_PING;
      wsfd_pkg::OP_PONG:  t = wsfd_pkg::BT_PONG;
      wsfd_pkg::OP_CONT: begin
        t = last_type;
        if (at_end && fr_fin && last_type == wsfd_pkg::BT_TEXT_FRAG) begin
          t = wsfd_pkg::BT_TEXT_MSG;
        end else if (at_end && fr_fin && last_type == wsfd_pkg::BT_BIN_FRAG) begin
          t = wsfd_pkg::BT_BIN_MSG;
        end
      end
      default:  t = last_type;
    endcase
    return t;
  endfunction

  task automatic expect_beat(input logic [7:0] d, input logic has, input logic [2:0] t,
                             input logic at_end, input logic err);
    wsfd_pkg::result_t r;
    r.data_byte    = d;
    r.has_data     = has;
    r.buffer_type  = t;
    r.frame_end    = at_end;
    r.length_error = err;
    expected_beats.push_back(r);
  endtask

  // The whole header is in, key included: check the length against the limit.
  // An oversize frame reports once and then freezes the parser for good.
  task automatic close_header();
    key_pos  = '0;
    hdr_left = '0;
    if (bytes_left > cfg_max_len) begin
      halted = 1'b1;
      expect_beat(8'h00, 1'b0, wsfd_pkg::BT_TEXT_FRAG, 1'b0, 1'b1);
    end else if (bytes_left == 64'd0) begin
      last_type   = beat_type(1'b1);
      parse_state = wsfd_pkg::PH_HDR0;
      expect_beat(8'h00, 1'b0, last_type, 1'b1, 1'b0);
    end else begin
      parse_state = wsfd_pkg::PH_PAYLOAD;
    end
  endtask

  // Length known: either collect the four key bytes or close the header now.
  task automatic length_known();
    if (fr_masked) begin
      parse_state = wsfd_pkg::PH_KEY;
      hdr_left    = 4'd4;
      mask_key    = '0;
    end else begin
      close_header();
    end
  endtask

  // Advances the predictor by one accepted input byte.
  task automatic deframe_byte(input logic [7:0] b);
    logic [6:0] len7;
    logic [7:0] d;
    logic       at_end;
    logic [2:0] t;
    if (halted) return;
    case (parse_state)
      wsfd_pkg::PH_HDR0: begin
        fr_op       = b[3:0];
        fr_fin      = b[7];
        parse_state = wsfd_pkg::PH_HDR1;
      end
      wsfd_pkg::PH_HDR1: begin
        fr_masked  = b[7];
        len7       = b[6:0];
        bytes_left = '0;
        if (len7 == wsfd_pkg::LEN_EXT16 || len7 == wsfd_pkg::LEN_EXT64) begin
          hdr_left    = (len7 == wsfd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
          parse_state = wsfd_pkg::PH_EXTLEN;
        end else begin
          bytes_left = {57'd0, len7};
          length_known();
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        // Extended lengths arrive most significant byte first.
        bytes_left = {bytes_left[55:0], b};
        hdr_left   = hdr_left - 4'd1;
        if (hdr_left == 4'd0) length_known();
      end
      wsfd_pkg::PH_KEY: begin
        mask_key = {mask_key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) close_header();
      end
      wsfd_pkg::PH_PAYLOAD: begin
        // The first key byte sits in the top bits and unmasks payload byte 0.
        d = b;
        if (fr_masked) d = d ^ mask_key[8 * (3 - key_pos) +: 8];
        key_pos    = key_pos + 2'd1;
        bytes_left = bytes_left - 64'd1;
        at_end     = (bytes_left == 64'd0);
        t          = beat_type(at_end);
        last_type  = t;
        if (at_end) parse_state = wsfd_pkg::PH_HDR0;
        expect_beat(d, 1'b1, t, at_end, 1'b0);
      end
      default: parse_state = wsfd_pkg::PH_HDR0;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_beat();
    wsfd_pkg::result_t want;
    if (expected_beats.size() == 0) begin
      $display("%0t: result beat expected none, got data_byte %0h has_data %0b",
               $time, data_byte, has_data);
      $display("%0t:   type %0d end %0b err %0b",
               $time, buffer_type, frame_end, length_error);
      mismatches++;
    end else begin
      want = expected_beats.pop_front();
      compare_field("data_byte", want.data_byte, data_byte);
      compare_field("has_data", 8'(want.has_data), 8'(has_data));
      compare_field("buffer_type", 8'(want.buffer_type), 8'(buffer_type));
      compare_field("frame_end", 8'(want.frame_end), 8'(frame_end));
      compare_field("length_error", 8'(want.length_error), 8'(length_error));
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor. Input beats feed the predictor before output beats are checked,
  // all in one process, so the result never hinges on which process the
  // simulator wakes first. The same block drives out_ready for the next edge
  // and runs the watchdog, whose check is deliberately the last statement.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left  = 0;
    end else begin
      if (in_valid && in_ready) deframe_byte(rx_byte);
      if (out_valid && out_ready) check_beat();

      // Receiver stalls come in bursts of random length.
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end

      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks. All of them start and end on a rising edge and touch each
  // signal at most once per edge.
  // --------------------------------------------------------------------------

  // Sends one byte beat, sometimes after a sender gap of random length.
  task automatic send_byte(input logic [7:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= value;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Sends a complete frame: header, optional key, then the payload unless the
  // announced length is over the limit (the block stops listening then).
  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic masked, input logic [63:0] len, input int form,
                            input logic [31:0] mkey);
    int i;
    send_byte({fin, rsv, op});
    case (form)
      FORM_LEN16: begin
        send_byte({masked, wsfd_pkg::LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      FORM_LEN64: begin
        send_byte({masked, wsfd_pkg::LEN_EXT64});
        for (i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
      default: send_byte({masked, len[6:0]});
    endcase
    if (masked) begin
      for (i = 3; i >= 0; i--) send_byte(mkey[8 * i +: 8]);
    end
    if (len <= cfg_max_len) begin
      for (i = 0; i < len; i++) send_byte(8'($urandom));
    end
  endtask

  // Stops input and waits until every predicted beat has come out, then lets
  // the block settle so that a register write lands while it is idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Reads max_payload_length back and compares it with the expected copy.
  task automatic check_max_len();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_LEN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== cfg_max_len) begin
      $display("%0t: max_payload_length expected %0h, got %0h", $time, cfg_max_len, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes max_payload_length (setup then access phase) and reads it back.
  task automatic write_max_len(input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_max_len = value;
    check_max_len();
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Every defined opcode, two reserved ones, fragmentation, all three length
  // encodings and zero length, under the reset limit.
  task automatic test_frame_kinds();
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_TEXT, 1'b0, 64'd3, FORM_LEN7, 32'h0);
    send_frame(1'b1, 3'b111, wsfd_pkg::OP_BIN, 1'b1, 64'd5, FORM_LEN7, 32'hFFFF_FFFF);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_TEXT, 1'b0, 64'd0, FORM_LEN7, 32'h0);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_PING, 1'b1, 64'd0, FORM_LEN7, $urandom);
    // A text message in three fragments; the last one turns it into a message.
    send_frame(1'b0, 3'b000, wsfd_pkg::OP_TEXT, 1'b1, 64'd2, FORM_LEN16, $urandom);
    send_frame(1'b0, 3'b000, wsfd_pkg::OP_CONT, 1'b0, 64'd1, FORM_LEN64, 32'h0);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_CONT, 1'b1, 64'd2, FORM_LEN7, $urandom);
    // A binary message closed by an empty continuation.
    send_frame(1'b0, 3'b000, wsfd_pkg::OP_BIN, 1'b0, 64'd1, FORM_LEN7, 32'h0);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_CONT, 1'b0, 64'd0, FORM_LEN16, 32'h0);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_CLOSE, 1'b0, 64'd2, FORM_LEN7, 32'h0);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_PONG, 1'b1, 64'd1, FORM_LEN64, 32'h1234_5678);
    // A continuation after a control frame keeps the control type.
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_CONT, 1'b0, 64'd1, FORM_LEN7, 32'h0);
    // A non-FIN text fragment, then a non-FIN control frame.
    send_frame(1'b0, 3'b010, wsfd_pkg::OP_TEXT, 1'b0, 64'd1, FORM_LEN7, 32'h0);
    send_frame(1'b0, 3'b000, wsfd_pkg::OP_PING, 1'b0, 64'd1, FORM_LEN7, 32'h0);
    // Reserved opcodes inherit the type of the beat before them.
    send_frame(1'b1, 3'b101, OP_RSV_LOW, 1'b1, 64'd2, FORM_LEN7, $urandom);
    send_frame(1'b0, 3'b000, OP_RSV_HIGH, 1'b0, 64'd0, FORM_LEN7, 32'h0);
  endtask

  // Reset value, a zero limit, a length equal to the limit, and the top value.
  task automatic test_length_limits();
    wait_idle();
    check_max_len();
    write_max_len(64'd0);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_TEXT, 1'b0, 64'd0, FORM_LEN7, 32'h0);
    send_frame(1'b0, 3'b000, wsfd_pkg::OP_BIN, 1'b1, 64'd0, FORM_LEN64, $urandom);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_CLOSE, 1'b0, 64'd0, FORM_LEN16, 32'h0);
    wait_idle();
    write_max_len(64'd4);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_BIN, 1'b1, 64'd4, FORM_LEN16, $urandom);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_TEXT, 1'b0, 64'd4, FORM_LEN64, 32'h0);
    wait_idle();
    write_max_len('1);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_PING, 1'b1, 64'd7, FORM_LEN64, $urandom);
  endtask

  // Random well-formed frames across several limit settings. One frame in four
  // carries a fully random opcode, reserved ones included, and lengths are
  // clamped to the current limit so the parser never halts here.
  task automatic send_random_frame();
    logic [3:0]  op;
    logic [63:0] len;
    int          pick;
    int          form;
    pick = $urandom_range(0, 15);
    case (pick)
      0, 1, 2: op = wsfd_pkg::OP_CONT;
      3, 4, 5: op = wsfd_pkg::OP_TEXT;
      6, 7, 8: op = wsfd_pkg::OP_BIN;
      9:       op = wsfd_pkg::OP_CLOSE;
      10:      op = wsfd_pkg::OP_PING;
      11:      op = wsfd_pkg::OP_PONG;
      default: op = 4'($urandom);
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      len = 64'd0;
    end else if (pick < 14) begin
      len = 64'($urandom_range(1, 8));
    end else if (pick < 19) begin
      len = 64'($urandom_range(9, 60));
    end else begin
      len = 64'($urandom_range(61, 300));
    end
    if (len > cfg_max_len) len = cfg_max_len;
    if (len > 64'd125 || $urandom_range(0, 3) == 0) begin
      form = $urandom_range(FORM_LEN16, FORM_LEN64);
    end else begin
      form = FORM_LEN7;
    end
    send_frame(1'($urandom_range(0, 1)), 3'($urandom), op, 1'($urandom_range(0, 1)),
               len, form, $urandom);
  endtask

  task automatic test_random_traffic();
    logic [63:0] limit;
    int          p;
    int          goal;
    for (p = 0; p < 8; p++) begin
      wait_idle();
      if (p == 7) begin
        limit = wsfd_pkg::MAX_LEN_RESET;
      end else begin
        case (p % 4)
          0:       limit = '1;
          1:       limit = 64'($urandom_range(1, 300));
          2:       limit = 64'd0;
          default: limit = 64'd125;
        endcase
      end
      write_max_len(limit);
      // Some phases run without any gaps or stalls; the last one always does.
      idle_on = (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
      goal    = bytes_sent + 150;
      while (bytes_sent < goal) send_random_frame();
    end
  endtask

  // An oversize frame with the top bit of a 64-bit length set. One error beat
  // comes out, after which the block ignores all input, also after a new limit.
  task automatic test_oversize_halt();
    wait_idle();
    write_max_len(64'd10);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_TEXT, 1'b1, 64'h8000_0000_0000_0005,
               FORM_LEN64, $urandom);
    wait_idle();
    repeat (16) send_byte(8'($urandom));
    wait_idle();
    write_max_len('1);
    send_frame(1'b1, 3'b000, wsfd_pkg::OP_BIN, 1'b0, 64'd3, FORM_LEN7, 32'h0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_frame_kinds();
    test_length_limits();
    test_random_traffic();
    test_oversize_halt();
    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
